// File: hw/rtl/trd_pkg.sv
// Shared types and constants for the tagged run-length decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int BYTE_W       = 8;
  localparam int CFG_W        = 24;
  localparam int OUT_TOTAL_W  = 24;
  localparam int LENGTH_BITS_DEF = 24;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COUNT = 2'd1,
    PH_DATA  = 2'd2
  } trd_phase_t;

  typedef enum logic {
    CFG_ESCAPE_TAG = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } trd_cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      out_byte;
    logic [BYTE_W-1:0]      run_length;
    logic                   end_of_stream;
    logic                   decode_error;
    logic [OUT_TOTAL_W-1:0] total_length;
  } trd_result_t;

endpackage

// File: hw/rtl/trd_decode.sv
// Decode stage: configuration registers, phase machine, running total and limit check.
// Depends on trd_pkg; produces one result word per accepted byte or none.
`timescale 1ns / 1ps

module trd_decode #(
  parameter int LENGTH_BITS = trd_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [trd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       accept,
  input  logic [trd_pkg::BYTE_W-1:0] src_byte,
  input  logic                       last_byte,
  output logic                       res_valid,
  output trd_pkg::trd_result_t       res
);
  import trd_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > CFG_W ? LENGTH_BITS : CFG_W) + 1;
  localparam logic [LENGTH_BITS-1:0] TOTAL_MAX = '1;

  logic [BYTE_W-1:0]      escape_tag_r;
  logic [CFG_W-1:0]       max_len_r;
  trd_phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]      pending_r, pending_nxt;
  logic [LENGTH_BITS-1:0] total_r, total_nxt;
  logic                   error_r, error_nxt;

  logic                   have_run_raw, truncated, have_run;
  logic [BYTE_W-1:0]      run_byte, run_len;
  logic [LENGTH_BITS:0]   sum_full;
  logic [LENGTH_BITS-1:0] sum_sat;
  logic                   over_limit;
  logic [LENGTH_BITS-1:0] total_after;
  logic                   error_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_tag_r <= '0;
      max_len_r    <= '0;
    end else if (cfg_we) begin
      case (trd_cfg_idx_t'(cfg_index))
        CFG_ESCAPE_TAG: escape_tag_r <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_LENGTH: max_len_r    <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    if (!error_r) begin
      case (phase_r)
        PH_IDLE: begin
          if (src_byte == escape_tag_r) phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          if (src_byte == '0) begin
            phase_nxt = PH_IDLE;
          end else begin
            pending_nxt = src_byte;
            phase_nxt   = PH_DATA;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // run outputs
  always_comb begin
    have_run_raw = 1'b0;
    run_byte     = '0;
    run_len      = '0;
    truncated    = 1'b0;
    if (!error_r) begin
      case (phase_r)
        PH_IDLE: begin
          if (src_byte == escape_tag_r) begin
            truncated = last_byte;
          end else begin
            have_run_raw = 1'b1;
            run_byte     = src_byte;
            run_len      = BYTE_W'(1);
          end
        end
        PH_COUNT: begin
          if (src_byte == '0) begin
            have_run_raw = 1'b1;
            run_byte     = escape_tag_r;
            run_len      = BYTE_W'(1);
          end else begin
            truncated = last_byte;
          end
        end
        default: begin
          have_run_raw = 1'b1;
          run_byte     = src_byte;
          run_len      = pending_r;
        end
      endcase
    end
  end

  always_comb begin
    sum_full    = {1'b0, total_r} + (LENGTH_BITS+1)'(run_len);
    sum_sat     = sum_full[LENGTH_BITS] ? TOTAL_MAX : sum_full[LENGTH_BITS-1:0];
    over_limit  = (max_len_r != '0) && (CMP_W'(sum_sat) > CMP_W'(max_len_r));
    have_run    = have_run_raw && !over_limit;
    total_after = have_run ? sum_sat : total_r;
    error_after = error_r || truncated || (have_run_raw && over_limit);
  end

  always_comb begin
    if (last_byte) begin
      total_nxt = '0;
      error_nxt = 1'b0;
    end else begin
      total_nxt = total_after;
      error_nxt = error_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pending_r <= '0;
      total_r   <= '0;
      error_r   <= 1'b0;
    end else if (accept) begin
      phase_r   <= last_byte ? PH_IDLE : phase_nxt;
      pending_r <= last_byte ? '0 : pending_nxt;
      total_r   <= total_nxt;
      error_r   <= error_nxt;
    end
  end

  assign res_valid         = accept && (have_run || last_byte);
  assign res.out_byte      = have_run ? run_byte : '0;
  assign res.run_length    = have_run ? run_len : '0;
  assign res.end_of_stream = last_byte;
  assign res.decode_error  = error_after;
  assign res.total_length  = OUT_TOTAL_W'(total_after);

  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> phase_r == PH_IDLE && total_r == '0 && !error_r)
    else $error("stream state not cleared after last byte");

  a_error_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && error_r |-> res.run_length == '0)
    else $error("run emitted while error is set");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) && !$past(last_byte) |-> total_r >= $past(total_r))
    else $error("running total decreased within a stream");

endmodule

// File: hw/rtl/trd_out_buf.sv
// Result register with a one-word skid stage between decode and the result channel.
// Depends on trd_pkg for the result word type.
`timescale 1ns / 1ps

module trd_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  trd_pkg::trd_result_t res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output trd_pkg::trd_result_t out_word
);
  import trd_pkg::*;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  trd_result_t main_r, main_nxt;
  trd_result_t skid_r, skid_nxt;
  logic        take;

  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!main_valid_r || take) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held without a result word");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && skid_valid_r))
    else $error("result written while skid stage full");

  a_park_in_skid: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && out_stall && !skid_valid_r && res_valid |=> skid_valid_r)
    else $error("stalled result not parked in skid stage");

endmodule

// File: hw/rtl/tagged_rle_decoder_unit.sv
// Tagged run-length decoder: accepts one compressed byte per cycle and returns
// one result word per run, plus an end word on the last byte. The decode stage
// works on each byte in the cycle it is accepted; the result is registered in
// the output register or the one-word skid stage, which lets a new byte enter
// while a result waits, so the sustained rate is one byte per clock while
// out_stall is low; in_stall rises only when both hold words. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while idle.
`timescale 1ns / 1ps

module tagged_rle_decoder_unit #(
  parameter int LENGTH_BITS = trd_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [trd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [trd_pkg::BYTE_W-1:0]      in_src_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [trd_pkg::BYTE_W-1:0]      out_byte,
  output logic [trd_pkg::BYTE_W-1:0]      out_run_length,
  output logic                            out_end_of_stream,
  output logic                            out_decode_error,
  output logic [trd_pkg::OUT_TOTAL_W-1:0] out_total_length
);
  import trd_pkg::*;

  logic        accept;
  logic        res_valid;
  logic        buf_full;
  trd_result_t res;
  trd_result_t out_word;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  trd_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .src_byte  (in_src_byte),
    .last_byte (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  trd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_byte          = out_word.out_byte;
  assign out_run_length    = out_word.run_length;
  assign out_end_of_stream = out_word.end_of_stream;
  assign out_decode_error  = out_word.decode_error;
  assign out_total_length  = out_word.total_length;

endmodule

// File: dv/tb_tagged_rle_decoder_unit.sv
// Self-checking testbench for tagged_rle_decoder_unit: directed and random
// compressed streams, with an in-bench predictor of decoded runs per word.
// Depends on trd_pkg and the tagged_rle_decoder_unit RTL only.
`timescale 1ns / 1ps

module tb_tagged_rle_decoder_unit;
  import trd_pkg::*;

  localparam int TOT_W       = LENGTH_BITS_DEF;
  localparam int HOLD_CYCLES = 200;
  localparam int LONG_RUNS   = 8;
  localparam int PHASE_WORDS = 110;

  // Running prediction of decoded runs and the queue of result words still owed.
  class rle_run_book;
    logic [BYTE_W-1:0] tag;
    logic [CFG_W-1:0]  limit;
    trd_phase_t        phase;
    logic [BYTE_W-1:0] count;
    logic [TOT_W-1:0]  total;
    bit                err;
    trd_result_t       owed_q[$];
    int                errors;

    function new();
      tag = '0;
      limit = '0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_IDLE;
      count = '0;
      total = '0;
      err = 1'b0;
    endfunction

    function void note_word(logic [BYTE_W-1:0] b, logic last);
      bit                have_run;
      bit                trunc;
      logic [BYTE_W-1:0] rbyte;
      logic [BYTE_W-1:0] rlen;
      logic [TOT_W:0]    sum;
      trd_result_t       r;
      have_run = 1'b0;
      trunc = 1'b0;
      rbyte = '0;
      rlen = '0;
      if (!err) begin
        case (phase)
          PH_IDLE: begin
            if (b == tag) begin
              phase = PH_COUNT;
              trunc = last;
            end else begin
              have_run = 1'b1;
              rbyte = b;
              rlen = 8'd1;
            end
          end
          PH_COUNT: begin
            if (b == '0) begin
              have_run = 1'b1;
              rbyte = tag;
              rlen = 8'd1;
              phase = PH_IDLE;
            end else begin
              count = b;
              phase = PH_DATA;
              trunc = last;
            end
          end
          default: begin
            have_run = 1'b1;
            rbyte = b;
            rlen = count;
            phase = PH_IDLE;
          end
        endcase
        if (trunc) err = 1'b1;
        if (have_run) begin
          sum = total + rlen;
          if (sum > {1'b0, {TOT_W{1'b1}}}) sum = {1'b0, {TOT_W{1'b1}}};
          if (limit != '0 && sum > limit) begin
            err = 1'b1;
            have_run = 1'b0;
          end else begin
            total = sum[TOT_W-1:0];
          end
        end
      end
      if (have_run || last) begin
        r.out_byte      = have_run ? rbyte : '0;
        r.run_length    = have_run ? rlen : '0;
        r.end_of_stream = last;
        r.decode_error  = err;
        r.total_length  = OUT_TOTAL_W'(total);
        owed_q.push_back(r);
      end
      if (last) clear();
    endfunction

    function void match_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(trd_result_t got);
      trd_result_t want;
      if (owed_q.size() == 0) begin
        $error("result word with none expected: byte %0d run %0d", got.out_byte,
               got.run_length);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      match_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
      match_field("run_length", 64'(want.run_length), 64'(got.run_length));
      match_field("end_of_stream", 64'(want.end_of_stream), 64'(got.end_of_stream));
      match_field("decode_error", 64'(want.decode_error), 64'(got.decode_error));
      match_field("total_length", 64'(want.total_length), 64'(got.total_length));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_src_byte = '0;
  logic                   in_last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic [BYTE_W-1:0]      out_run_length;
  logic                   out_end_of_stream;
  logic                   out_decode_error;
  logic [OUT_TOTAL_W-1:0] out_total_length;

  bit                idle_en = 1'b1;
  bit                hold_req = 1'b0;
  logic [BYTE_W-1:0] stream_q[$];
  rle_run_book       book = new();

  tagged_rle_decoder_unit #(.LENGTH_BITS(TOT_W)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_src_byte       (in_src_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_length    (out_run_length),
    .out_end_of_stream (out_end_of_stream),
    .out_decode_error  (out_decode_error),
    .out_total_length  (out_total_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) book.note_word(in_src_byte, in_last_byte);
    if (rst_n && out_valid && !out_stall)
      book.check_word(trd_result_t'({out_byte, out_run_length, out_end_of_stream,
                                     out_decode_error, out_total_length}));
  end

  // Receiver: random stall bursts, plus one long hold when asked.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (idle_en ? $urandom_range(1, 11) : 1) @(posedge clk);
      end
    end
  end

  initial begin
    #1_500_000;
    $display("tb_tagged_rle_decoder_unit: done, errors");
    $finish;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_byte  <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_stream();
    for (int i = 0; i < stream_q.size(); i++) push_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Drop valid, then wait for every owed word and let the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.owed_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (book.owed_q.size() != 0) begin
      $error("%0d result words never arrived", book.owed_q.size());
      book.errors++;
      book.owed_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input trd_cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_ESCAPE_TAG) book.tag = val[BYTE_W-1:0];
    else book.limit = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed tokens; some raw noise and truncated endings.
  task automatic build_stream();
    int                tokens;
    int                kind;
    logic [BYTE_W-1:0] t;
    t = book.tag;
    stream_q.delete();
    tokens = $urandom_range(1, 12);
    for (int i = 0; i < tokens; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        stream_q.push_back(t + 8'($urandom_range(1, 255)));
      end else if (kind == 4) begin
        stream_q.push_back(t);
        stream_q.push_back(8'h00);
      end else if (kind <= 8) begin
        stream_q.push_back(t);
        if ($urandom_range(0, 4) == 0) stream_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h01);
        else stream_q.push_back(8'($urandom_range(1, $urandom_range(1, 255))));
        stream_q.push_back(8'($urandom));
      end else begin
        stream_q.push_back(8'($urandom));
      end
    end
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      stream_q.push_back(t);
    end else if (kind == 1) begin
      stream_q.push_back(t);
      stream_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic random_phase(input logic [BYTE_W-1:0] tag, input logic [CFG_W-1:0] limit,
                              input int target, input bit with_hold);
    int sent;
    bit held;
    sent = 0;
    held = 1'b0;
    drain();
    cfg_write(CFG_ESCAPE_TAG, CFG_W'(tag));
    cfg_write(CFG_MAX_LENGTH, limit);
    while (sent < target) begin
      if (with_hold && !held && sent > target / 2) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      build_stream();
      push_stream();
      sent += stream_q.size();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: tag 0, no limit. Plain, literal tag, runs of 1 and 255.
    stream_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'hFF, 8'h00, 8'h01};
    push_stream();
    stream_q = '{8'h00};
    push_stream();
    stream_q = '{8'h00, 8'h05};
    push_stream();

    // Tag 255, limit 10: hit the limit exactly, overflow, drop, overflow on last.
    drain();
    cfg_write(CFG_ESCAPE_TAG, 24'hFF);
    cfg_write(CFG_MAX_LENGTH, 24'd10);
    stream_q = '{8'h00, 8'hFF, 8'h09, 8'h33, 8'h44, 8'h55};
    push_stream();
    stream_q = '{8'hFF, 8'h00};
    push_stream();
    stream_q = '{8'hFF, 8'h0B, 8'h66};
    push_stream();

    random_phase(8'hFF, 24'd0, PHASE_WORDS, 1'b0);
    random_phase(8'($urandom), 24'hFF_FFFF, PHASE_WORDS, 1'b0);
    random_phase(8'h00, 24'($urandom_range(20, 400)), PHASE_WORDS, 1'b1);
    random_phase(8'($urandom), 24'($urandom_range(1, 30)), PHASE_WORDS, 1'b0);
    random_phase(8'($urandom), 24'd0, PHASE_WORDS, 1'b0);
    drain();
    idle_en = 1'b0;
    random_phase(8'($urandom), 24'($urandom_range(100, 2000)), PHASE_WORDS, 1'b0);

    // Back-to-back runs of 255 with no limit.
    drain();
    cfg_write(CFG_ESCAPE_TAG, 24'h00);
    cfg_write(CFG_MAX_LENGTH, 24'd0);
    for (int i = 0; i < LONG_RUNS; i++) begin
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'($urandom), 1'b0);
    end
    push_byte(8'h07, 1'b1);
    drain();

    if (book.errors == 0) begin
      $display("tb_tagged_rle_decoder_unit: done, clean");
    end else begin
      $display("tb_tagged_rle_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: tagged_rle_decoder_unit.f
hw/rtl/trd_pkg.sv
hw/rtl/trd_decode.sv
hw/rtl/trd_out_buf.sv
hw/rtl/tagged_rle_decoder_unit.sv
dv/tb_tagged_rle_decoder_unit.sv
